// ----- hw/rtl/va3d_pkg.sv -----
// Shared types, widths and the arctangent table for the 3D vector angle block.
package va3d_pkg;

  localparam int COMPONENT_BITS      = 16;
  localparam int ANGLE_FRACTION_BITS = 14;
  localparam int ANGLE_W   = ANGLE_FRACTION_BITS + 2;
  localparam int MAG_W     = COMPONENT_BITS + 1;
  localparam int NORM_MSB  = COMPONENT_BITS - 2;
  localparam int CMP_W     = COMPONENT_BITS + 2;
  localparam int PROD_W    = 2 * CMP_W;
  localparam int LEN_W     = 2 * COMPONENT_BITS;
  localparam int DOT_W     = LEN_W + 1;
  localparam int RAD_W     = 2 * LEN_W;
  localparam int ROOT_W    = LEN_W;
  localparam int REM_W     = LEN_W + 4;
  localparam int ACC_FRAC  = 30;
  localparam int STEPS     = 31;
  localparam int IDX_W     = 5;
  localparam int XY_W      = LEN_W + 5;
  localparam int ACC_W     = 35;
  localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRACTION_BITS;

  localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 35'sd1686629713;
  localparam logic signed [ACC_W-1:0] PI_ACC      = 35'sd3373259426;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] first_x;
    logic signed [COMPONENT_BITS-1:0] first_y;
    logic signed [COMPONENT_BITS-1:0] first_z;
    logic signed [COMPONENT_BITS-1:0] second_x;
    logic signed [COMPONENT_BITS-1:0] second_y;
    logic signed [COMPONENT_BITS-1:0] second_z;
  } operands_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               zero_vector;
  } result_t;

  // Side information that travels with a transaction down the chains.
  typedef struct packed {
    logic              valid;
    logic              zero;
    logic              dneg;
    logic [LEN_W-1:0]  dmag;
  } tag_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } cordic_t;

  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [IDX_W-1:0] i);
    logic signed [ACC_W-1:0] t;
    unique case (i)
      5'd0: t = 35'sd843314857;
      5'd1: t = 35'sd497837829;
      5'd2: t = 35'sd263043837;
      5'd3: t = 35'sd133525159;
      5'd4: t = 35'sd67021687;
      5'd5: t = 35'sd33543516;
      5'd6: t = 35'sd16775851;
      5'd7: t = 35'sd8388437;
      5'd8: t = 35'sd4194283;
      5'd9: t = 35'sd2097149;
      default: t = ACC_W'(64'sd1 <<< (ACC_FRAC - int'(i)));
    endcase
    return t;
  endfunction

  // Arithmetic shift right that truncates toward zero.
  function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                   input logic [IDX_W-1:0] sh);
    logic [XY_W-1:0] mag;
    logic [XY_W-1:0] m;
    mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
    m = mag >> sh;
    return v[XY_W-1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ----- hw/rtl/va3d_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cycle.
module va3d_sqrt_cell
  import va3d_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  tag_t  tag_in,
  input  sqrt_t data_in,
  output tag_t  tag_out,
  output sqrt_t data_out
);

  logic [REM_W-1:0] rem2;
  logic [REM_W-1:0] trial;
  logic             take;
  sqrt_t            data_next;

  always_comb begin
    rem2  = {data_in.rem[REM_W-3:0], data_in.rad[RAD_W-1 -: 2]};
    trial = REM_W'({data_in.root, 2'b01});
    take  = rem2 >= trial;
    data_next.rad  = {data_in.rad[RAD_W-3:0], 2'b00};
    data_next.rem  = take ? rem2 - trial : rem2;
    data_next.root = {data_in.root[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.zero <= tag_in.zero;
    tag_out.dneg <= tag_in.dneg;
    tag_out.dmag <= tag_in.dmag;
    data_out     <= data_next;
  end

endmodule

// ----- hw/rtl/va3d_cordic_cell.sv -----
// One cell of the vectoring chain: one micro-rotation per cycle.
module va3d_cordic_cell
  import va3d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  tag_t             tag_in,
  input  cordic_t          data_in,
  output tag_t             tag_out,
  output cordic_t          data_out
);

  logic signed [XY_W-1:0]  xs;
  logic signed [XY_W-1:0]  ys;
  logic signed [ACC_W-1:0] t;
  cordic_t                 data_next;

  always_comb begin
    xs = shr_tz(data_in.x, idx);
    ys = shr_tz(data_in.y, idx);
    t  = atan_entry(idx);
    if (data_in.y > 0) begin
      data_next.x   = data_in.x + ys;
      data_next.y   = data_in.y - xs;
      data_next.acc = data_in.acc + t;
    end else begin
      data_next.x   = data_in.x - ys;
      data_next.y   = data_in.y + xs;
      data_next.acc = data_in.acc - t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.zero <= tag_in.zero;
    tag_out.dneg <= tag_in.dneg;
    tag_out.dmag <= tag_in.dmag;
    data_out     <= data_next;
  end

endmodule

// ----- hw/rtl/vector_angle_3d_core.sv -----
// Top level: angle between two 3D vectors, pipelined one transaction per cycle.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+-------------------------------
//  operands | operands (operands_t)  | accepted when start && !busy
//  result   | result (result_t)      | shown for one cycle with done
//
// A transaction is accepted every cycle; its result passes through these registered stages:
// normalize, products, sums, wide products, difference (5), the square root
// chain (32 cells), CORDIC setup (1), the CORDIC chain (31 cells), rounding (1).
// busy stays low; the receiver cannot stall, so nothing is ever held back.
// Synchronous reset clears the valid bits of every stage.
module vector_angle_3d_core
  import va3d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  operands_t operands,
  output logic      done,
  output result_t   result
);

  typedef logic signed [CMP_W-1:0] cmp_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [COMPONENT_BITS-1:0] v);
    logic signed [MAG_W-1:0] w;
    w = MAG_W'(v);
    return w[MAG_W-1] ? MAG_W'(-w) : MAG_W'(w);
  endfunction

  // Shifts a vector left until the top set bit of its largest magnitude reaches bit NORM_MSB.
  function automatic logic [3*CMP_W:0] norm_vec(input logic signed [COMPONENT_BITS-1:0] c0,
                                               input logic signed [COMPONENT_BITS-1:0] c1,
                                               input logic signed [COMPONENT_BITS-1:0] c2);
    logic [MAG_W-1:0] m0;
    logic [MAG_W-1:0] m1;
    logic [MAG_W-1:0] m2;
    logic [MAG_W-1:0] mx;
    logic [IDX_W-1:0] msb;
    logic [IDX_W-1:0] sh;
    cmp_t             r0;
    cmp_t             r1;
    cmp_t             r2;
    m0 = mag_of(c0);
    m1 = mag_of(c1);
    m2 = mag_of(c2);
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
    msb = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (mx[k]) msb = IDX_W'(k);
    end
    sh = (msb < IDX_W'(NORM_MSB)) ? IDX_W'(NORM_MSB) - msb : '0;
    r0 = $signed(CMP_W'(m0 << sh));
    r1 = $signed(CMP_W'(m1 << sh));
    r2 = $signed(CMP_W'(m2 << sh));
    if (c0[COMPONENT_BITS-1]) r0 = -r0;
    if (c1[COMPONENT_BITS-1]) r1 = -r1;
    if (c2[COMPONENT_BITS-1]) r2 = -r2;
    return {mx == '0, r0, r1, r2};
  endfunction

  logic [3*CMP_W:0] na;
  logic [3*CMP_W:0] nb;

  logic v1, v2, v3, v4, v5, v6;
  logic z1, z2, z3, z4, z5;
  cmp_t a1 [3];
  cmp_t b1 [3];
  logic signed [PROD_W-1:0] pab [3];
  logic signed [PROD_W-1:0] paa [3];
  logic signed [PROD_W-1:0] pbb [3];
  logic signed [DOT_W-1:0]  dot;
  logic [LEN_W-1:0]         la;
  logic [LEN_W-1:0]         lb;
  logic [LEN_W-1:0]         dmag3;
  logic [RAD_W-1:0]         plab;
  logic [RAD_W-1:0]         pdd;
  logic                     dneg4, dneg5;
  logic [LEN_W-1:0]         dmag4, dmag5;
  logic [RAD_W-1:0]         diff;
  logic signed [PROD_W-1:0] dot_sum;
  logic signed [PROD_W-1:0] la_sum;
  logic signed [PROD_W-1:0] lb_sum;

  tag_t    sq_tag  [ROOT_W+1];
  sqrt_t   sq_data [ROOT_W+1];
  tag_t    co_tag  [STEPS+1];
  cordic_t co_data [STEPS+1];

  logic signed [ACC_W-1:0] acc_c;
  logic [ACC_W-1:0]        acc_r;
  result_t                 result_next;

  assign busy = 1'b0;
  assign na = norm_vec(operands.first_x, operands.first_y, operands.first_z);
  assign nb = norm_vec(operands.second_x, operands.second_y, operands.second_z);

  assign dot_sum = pab[0] + pab[1] + pab[2];
  assign la_sum  = paa[0] + paa[1] + paa[2];
  assign lb_sum  = pbb[0] + pbb[1] + pbb[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    z1 <= na[3*CMP_W] || nb[3*CMP_W];
    a1[0] <= na[3*CMP_W-1 -: CMP_W];
    a1[1] <= na[2*CMP_W-1 -: CMP_W];
    a1[2] <= na[CMP_W-1:0];
    b1[0] <= nb[3*CMP_W-1 -: CMP_W];
    b1[1] <= nb[2*CMP_W-1 -: CMP_W];
    b1[2] <= nb[CMP_W-1:0];
    z2 <= z1;
    for (int k = 0; k < 3; k++) begin
      pab[k] <= a1[k] * b1[k];
      paa[k] <= a1[k] * a1[k];
      pbb[k] <= b1[k] * b1[k];
    end
    z3    <= z2;
    dot   <= DOT_W'(dot_sum);
    la    <= LEN_W'(la_sum);
    lb    <= LEN_W'(lb_sum);
    z4    <= z3;
    dneg4 <= dot[DOT_W-1];
    dmag4 <= dmag3;
    plab  <= la * lb;
    pdd   <= dmag3 * dmag3;
    z5    <= z4;
    dneg5 <= dneg4;
    dmag5 <= dmag4;
    diff  <= plab - pdd;
  end

  assign dmag3 = dot[DOT_W-1] ? LEN_W'(-dot) : LEN_W'(dot);

  assign sq_tag[0]  = '{valid: v5, zero: z5, dneg: dneg5, dmag: dmag5};
  assign sq_data[0] = '{rad: diff, rem: '0, root: '0};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    va3d_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tag_in   (sq_tag[g]),
      .data_in  (sq_data[g]),
      .tag_out  (sq_tag[g+1]),
      .data_out (sq_data[g+1])
    );
  end

  // For an obtuse angle the pair is pre-rotated by a quarter turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      co_tag[0].valid <= 1'b0;
    end else begin
      co_tag[0].valid <= sq_tag[ROOT_W].valid;
    end
    co_tag[0].zero <= sq_tag[ROOT_W].zero;
    co_tag[0].dneg <= sq_tag[ROOT_W].dneg;
    co_tag[0].dmag <= sq_tag[ROOT_W].dmag;
    if (sq_tag[ROOT_W].dneg) begin
      co_data[0].x   <= $signed(XY_W'(sq_data[ROOT_W].root));
      co_data[0].y   <= $signed(XY_W'(sq_tag[ROOT_W].dmag));
      co_data[0].acc <= HALF_PI_ACC;
    end else begin
      co_data[0].x   <= $signed(XY_W'(sq_tag[ROOT_W].dmag));
      co_data[0].y   <= $signed(XY_W'(sq_data[ROOT_W].root));
      co_data[0].acc <= '0;
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_cordic
    va3d_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(g)),
      .tag_in   (co_tag[g]),
      .data_in  (co_data[g]),
      .tag_out  (co_tag[g+1]),
      .data_out (co_data[g+1])
    );
  end

  always_comb begin
    acc_c = co_data[STEPS].acc;
    if (acc_c < 0) acc_c = '0;
    if (acc_c > PI_ACC) acc_c = PI_ACC;
    acc_r = ACC_W'(acc_c) + (ACC_W'(1) << (RND_SHIFT - 1));
    result_next.angle       = co_tag[STEPS].zero ? '0 : ANGLE_W'(acc_r >> RND_SHIFT);
    result_next.zero_vector = co_tag[STEPS].zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= co_tag[STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  assign done = v6;

endmodule
